// File: rtl/tsrp_pkg.sv
`timescale 1ns / 1ps

package tsrp_pkg;

	localparam int MOVE_W     = 24;
	localparam int INTV_W     = 16;
	localparam int VEL_W      = 32;
	localparam int ACC_W      = 20;
	localparam int MAXV_W     = 16;
	localparam int RAMP_W     = 24;
	localparam int CLK_W      = 27;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 27;
	localparam int DIV_DV_W   = VEL_W + 1;

	localparam logic [INTV_W-1:0] INTV_MAX = '1;

	localparam logic [ACC_W-1:0]  ACCEL_RST = 20'd10000;
	localparam logic [MAXV_W-1:0] MAXV_RST  = 16'd5000;
	localparam logic [RAMP_W-1:0] RAMP_RST  = 24'd1250;
	localparam logic [CLK_W-1:0]  CLK_RST   = 27'd16000000;

	localparam logic OP_START = 1'b0;

	localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_RATE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_VELOCITY = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RAMP_STEPS   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_HZ     = 2'd3;

	typedef enum logic [1:0] {
		PH_ACCEL  = 2'd0,
		PH_CRUISE = 2'd1,
		PH_DECEL  = 2'd2,
		PH_IDLE   = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		ST_WAIT,
		ST_EVAL,
		ST_RATE,
		ST_INC,
		ST_APPLY,
		ST_INTV,
		ST_FIN
	} seq_state_t;

	typedef struct packed {
		logic [ACC_W-1:0]  accel_rate;
		logic [MAXV_W-1:0] max_velocity;
		logic [RAMP_W-1:0] ramp_steps;
		logic [CLK_W-1:0]  clock_hz;
	} cfg_regs_t;

endpackage

// File: rtl/tsrp_if.sv
`timescale 1ns / 1ps

interface tsrp_cmd_if;
	logic                          valid;
	logic                          ready;
	logic                          op;
	logic [tsrp_pkg::MOVE_W-1:0]   move_steps;

	modport source (output valid, output op, output move_steps, input ready);
	modport sink (input valid, input op, input move_steps, output ready);
endinterface

interface tsrp_res_if;
	logic                          valid;
	logic                          ready;
	logic [tsrp_pkg::INTV_W-1:0]   step_interval;
	logic [tsrp_pkg::VEL_W-1:0]    velocity;
	logic [1:0]                    phase;
	logic                          move_done;

	modport source (output valid, output step_interval, output velocity, output phase,
		output move_done, input ready);
	modport sink (input valid, input step_interval, input velocity, input phase,
		input move_done, output ready);
endinterface

interface tsrp_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [tsrp_pkg::CFG_IDX_W-1:0]    index;
	logic [tsrp_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/trapezoidal_step_rate_profile_core.sv
`timescale 1ns / 1ps
// channel  dir  payload                                     accepted when
// cmd      in   op, move_steps                              cmd.valid & cmd.ready
// res      out  step_interval, velocity, phase, move_done   res.valid & res.ready
// cfg      in   index, data                                 cfg.valid & cfg.ready (always ready)
//
// a start request or a tick while idle goes from ST_WAIT straight to ST_FIN and runs no division
// a cruise tick runs at most one division, for the step interval
// accelerate / decelerate ticks run up to three divisions on the one bit-serial divider,
// one after another: step rate, velocity increment, then step interval
// one request at a time; the next is taken while the previous result still waits
// arst_n clears the profile state to idle with interval 65535; config regs reset to defaults

module trapezoidal_step_rate_profile_core #(
	parameter int STEP_COUNT_BITS = 24,
	parameter int FRAC_BITS       = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	tsrp_cmd_if.sink    cmd,
	tsrp_res_if.source  res,
	tsrp_cfg_if.sink    cfg
);

	localparam int DIV_DW = tsrp_pkg::CLK_W + FRAC_BITS;

	tsrp_pkg::cfg_regs_t              cfg_q;
	logic                             div_go;
	logic                             div_done;
	logic [DIV_DW-1:0]                div_dividend;
	logic [DIV_DW-1:0]                div_quotient;
	logic [tsrp_pkg::DIV_DV_W-1:0]    div_divisor;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.accel_rate   <= tsrp_pkg::ACCEL_RST;
			cfg_q.max_velocity <= tsrp_pkg::MAXV_RST;
			cfg_q.ramp_steps   <= tsrp_pkg::RAMP_RST;
			cfg_q.clock_hz     <= tsrp_pkg::CLK_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				tsrp_pkg::CFG_ACCEL_RATE:
					cfg_q.accel_rate <= cfg.data[tsrp_pkg::ACC_W-1:0];
				tsrp_pkg::CFG_MAX_VELOCITY:
					cfg_q.max_velocity <= cfg.data[tsrp_pkg::MAXV_W-1:0];
				tsrp_pkg::CFG_RAMP_STEPS:
					cfg_q.ramp_steps <= cfg.data[tsrp_pkg::RAMP_W-1:0];
				tsrp_pkg::CFG_CLOCK_HZ:
					cfg_q.clock_hz <= cfg.data[tsrp_pkg::CLK_W-1:0];
				default: ;
			endcase
		end
	end

	tsrp_ctrl #(
		.STEP_COUNT_BITS (STEP_COUNT_BITS),
		.FRAC_BITS       (FRAC_BITS)
	) u_ctrl (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg               (cfg_q),
		.cmd_valid         (cmd.valid),
		.cmd_ready         (cmd.ready),
		.cmd_op            (cmd.op),
		.cmd_move_steps    (cmd.move_steps),
		.res_valid         (res.valid),
		.res_ready         (res.ready),
		.res_step_interval (res.step_interval),
		.res_velocity      (res.velocity),
		.res_phase         (res.phase),
		.res_move_done     (res.move_done),
		.div_go            (div_go),
		.div_dividend      (div_dividend),
		.div_divisor       (div_divisor),
		.div_done          (div_done),
		.div_quotient      (div_quotient)
	);

	tsrp_div #(
		.DIVIDEND_W (DIV_DW),
		.DIVISOR_W  (tsrp_pkg::DIV_DV_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (div_go),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quotient)
	);

`ifndef SYNTH
	a_busy_after_request: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid && cmd.ready |=> !cmd.ready)
		else $error("request accepted while a request was in progress");

	a_div_multicycle: assert property (@(posedge clk) disable iff (!arst_n)
		div_go |=> !div_done)
		else $error("divider finished right after launch");

	a_done_goes_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.move_done |-> res.phase == tsrp_pkg::PH_IDLE)
		else $error("move end reported without idle phase");

	a_interval_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> res.step_interval != '0)
		else $error("zero step interval");
`endif

endmodule

// File: rtl/tsrp_div.sv
`timescale 1ns / 1ps

module tsrp_div #(
	parameter int DIVIDEND_W = 43,
	parameter int DIVISOR_W  = 33
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  go,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]  divisor,
	output logic                  done,
	output logic [DIVIDEND_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DIVIDEND_W);

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  dsor_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W:0]    sh;
	logic                  ge;
	logic [DIVISOR_W-1:0]  rem_nx;

	// restoring division, one quotient bit per cycle, msb first
	assign sh     = {rem_q, quo_q[DIVIDEND_W-1]};
	assign ge     = sh >= {1'b0, dsor_q};
	assign rem_nx = ge ? DIVISOR_W'(sh - {1'b0, dsor_q}) : sh[DIVISOR_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIVIDEND_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			quo_q  <= dividend;
			rem_q  <= '0;
			dsor_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_nx;
			quo_q <= {quo_q[DIVIDEND_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// File: rtl/tsrp_ctrl.sv
`timescale 1ns / 1ps

module tsrp_ctrl #(
	parameter int STEP_COUNT_BITS = 24,
	parameter int FRAC_BITS       = 16
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  tsrp_pkg::cfg_regs_t                       cfg,
	input  logic                                      cmd_valid,
	output logic                                      cmd_ready,
	input  logic                                      cmd_op,
	input  logic [tsrp_pkg::MOVE_W-1:0]               cmd_move_steps,
	output logic                                      res_valid,
	input  logic                                      res_ready,
	output logic [tsrp_pkg::INTV_W-1:0]               res_step_interval,
	output logic [tsrp_pkg::VEL_W-1:0]                res_velocity,
	output logic [1:0]                                res_phase,
	output logic                                      res_move_done,
	output logic                                      div_go,
	output logic [tsrp_pkg::CLK_W+FRAC_BITS-1:0]      div_dividend,
	output logic [tsrp_pkg::DIV_DV_W-1:0]             div_divisor,
	input  logic                                      div_done,
	input  logic [tsrp_pkg::CLK_W+FRAC_BITS-1:0]      div_quotient
);

	localparam int SCB   = STEP_COUNT_BITS;
	localparam int DW    = tsrp_pkg::CLK_W + FRAC_BITS;
	localparam int VW    = tsrp_pkg::VEL_W;
	localparam int IW    = tsrp_pkg::INTV_W;
	localparam int WIDE  = (SCB > tsrp_pkg::MOVE_W) ? SCB : tsrp_pkg::MOVE_W;
	localparam int WIDE1 = WIDE + 1;
	localparam int VM_W  = tsrp_pkg::MAXV_W + FRAC_BITS;
	localparam int EXT_W = 48;
	localparam int ACS_W = tsrp_pkg::ACC_W + FRAC_BITS;

	localparam logic [SCB-1:0] STEP_SAT  = '1;
	localparam logic [VW-1:0]  SPEED_SAT = '1;
	localparam logic [VW-1:0]  ONE_Q     = VW'(1) << FRAC_BITS;

	tsrp_pkg::seq_state_t state_q, state_d;
	tsrp_pkg::phase_t     phase_q;
	tsrp_pkg::phase_t     res_phase_q;

	logic                        go_q, go_d;
	logic                        res_load;
	logic                        res_vld_q;
	logic [SCB-1:0]              steps_q, move_q, ramp_q, steps_inc;
	logic [VW-1:0]               speed_q;
	logic [IW-1:0]               cmp_q;
	logic                        done_q;
	logic [tsrp_pkg::CLK_W-1:0]  rate_q;
	logic [VW-1:0]               inc_q;
	logic [IW-1:0]               res_intv_q;
	logic [VW-1:0]               res_vel_q;
	logic                        res_done_q;

	logic [WIDE-1:0]             mv_w, rs_w;
	logic [SCB-1:0]              mv_len, rs_len, ramp_len;
	logic [WIDE:0]               ramp_x2;
	logic [VM_W-1:0]             vm_w;
	logic [EXT_W-1:0]            vm_x;
	logic [VW-1:0]               vm_sat;
	logic [VW-1:0]               spd_floor;
	logic [VW:0]                 acc_sum;
	logic [VW-1:0]               acc_spd, dec_spd;
	logic [ACS_W-1:0]            acc_sh;
	logic [tsrp_pkg::CLK_W-1:0]  rate_nx;
	logic [VW-1:0]               inc_sat;
	logic [IW-1:0]               intv_sat;

	// start: move length and ramp capped to half the move
	assign mv_w     = WIDE'(cmd_move_steps);
	assign mv_len   = mv_w[SCB-1:0];
	assign rs_w     = WIDE'(cfg.ramp_steps);
	assign rs_len   = rs_w[SCB-1:0];
	assign ramp_x2  = {rs_w, 1'b0};
	assign ramp_len = (ramp_x2 > WIDE1'(mv_len)) ? (mv_len >> 1) : rs_len;

	assign steps_inc = (steps_q == STEP_SAT) ? steps_q : steps_q + SCB'(1);

	assign vm_w   = {cfg.max_velocity, {FRAC_BITS{1'b0}}};
	assign vm_x   = EXT_W'(vm_w);
	assign vm_sat = (vm_x[EXT_W-1:VW] != '0) ? SPEED_SAT : vm_x[VW-1:0];

	assign spd_floor = (speed_q[VW-1:FRAC_BITS] == '0) ? ONE_Q : speed_q;

	assign acc_sum = {1'b0, speed_q} + {1'b0, inc_q};
	assign acc_spd = acc_sum[VW] ? SPEED_SAT : acc_sum[VW-1:0];
	assign dec_spd = (inc_q >= speed_q) ? '0 : speed_q - inc_q;

	assign acc_sh   = {cfg.accel_rate, {FRAC_BITS{1'b0}}};
	assign rate_nx  = div_quotient[tsrp_pkg::CLK_W-1:0];
	assign inc_sat  = (div_quotient[DW-1:VW] != '0) ? SPEED_SAT : div_quotient[VW-1:0];
	assign intv_sat = (div_quotient[DW-1:IW] != '0) ? tsrp_pkg::INTV_MAX :
		(div_quotient[IW-1:0] == '0) ? IW'(1) : div_quotient[IW-1:0];

	// operands for the shared divider follow the sequencer state
	always_comb begin
		case (state_q)
			tsrp_pkg::ST_RATE: begin
				div_dividend = DW'(cfg.clock_hz);
				div_divisor  = tsrp_pkg::DIV_DV_W'(cmp_q);
			end
			tsrp_pkg::ST_INC: begin
				div_dividend = DW'(acc_sh);
				div_divisor  = tsrp_pkg::DIV_DV_W'(rate_q);
			end
			default: begin
				div_dividend = {cfg.clock_hz, {FRAC_BITS{1'b0}}};
				div_divisor  = {spd_floor, 1'b0};
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tsrp_pkg::ST_WAIT;
			go_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			go_q    <= go_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		go_d      = 1'b0;
		cmd_ready = 1'b0;
		res_load  = 1'b0;
		unique case (state_q)
			tsrp_pkg::ST_WAIT: begin
				cmd_ready = 1'b1;
				if (cmd_valid) begin
					if (cmd_op == tsrp_pkg::OP_START || phase_q == tsrp_pkg::PH_IDLE)
						state_d = tsrp_pkg::ST_FIN;
					else
						state_d = tsrp_pkg::ST_EVAL;
				end
			end
			tsrp_pkg::ST_EVAL: begin
				state_d = tsrp_pkg::ST_FIN;
				case (phase_q)
					tsrp_pkg::PH_ACCEL: begin
						if (steps_q >= ramp_q) begin
							if (vm_sat != '0) begin
								state_d = tsrp_pkg::ST_INTV;
								go_d    = 1'b1;
							end
						end else begin
							state_d = tsrp_pkg::ST_RATE;
							go_d    = 1'b1;
						end
					end
					tsrp_pkg::PH_CRUISE: begin
						if (speed_q != '0) begin
							state_d = tsrp_pkg::ST_INTV;
							go_d    = 1'b1;
						end
					end
					tsrp_pkg::PH_DECEL: begin
						if (steps_q < move_q) begin
							state_d = tsrp_pkg::ST_RATE;
							go_d    = 1'b1;
						end
					end
					default: ;
				endcase
			end
			tsrp_pkg::ST_RATE: begin
				if (div_done) begin
					// zero rate means the increment saturates, no second division
					if (rate_nx == '0) begin
						state_d = tsrp_pkg::ST_APPLY;
					end else begin
						state_d = tsrp_pkg::ST_INC;
						go_d    = 1'b1;
					end
				end
			end
			tsrp_pkg::ST_INC: begin
				if (div_done)
					state_d = tsrp_pkg::ST_APPLY;
			end
			tsrp_pkg::ST_APPLY: begin
				state_d = tsrp_pkg::ST_FIN;
				if (phase_q == tsrp_pkg::PH_ACCEL) begin
					if (acc_spd != '0) begin
						state_d = tsrp_pkg::ST_INTV;
						go_d    = 1'b1;
					end
				end else if (dec_spd[VW-1:FRAC_BITS] != '0) begin
					state_d = tsrp_pkg::ST_INTV;
					go_d    = 1'b1;
				end
			end
			tsrp_pkg::ST_INTV: begin
				if (div_done)
					state_d = tsrp_pkg::ST_FIN;
			end
			tsrp_pkg::ST_FIN: begin
				if (!res_vld_q || res_ready) begin
					res_load = 1'b1;
					state_d  = tsrp_pkg::ST_WAIT;
				end
			end
			default: state_d = tsrp_pkg::ST_WAIT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= tsrp_pkg::PH_IDLE;
			steps_q <= '0;
			move_q  <= '0;
			ramp_q  <= '0;
			speed_q <= '0;
			cmp_q   <= tsrp_pkg::INTV_MAX;
			done_q  <= 1'b0;
		end else begin
			case (state_q)
				tsrp_pkg::ST_WAIT: begin
					if (cmd_valid) begin
						done_q <= 1'b0;
						if (cmd_op == tsrp_pkg::OP_START) begin
							move_q  <= mv_len;
							ramp_q  <= ramp_len;
							steps_q <= '0;
							speed_q <= '0;
							phase_q <= tsrp_pkg::PH_ACCEL;
							cmp_q   <= tsrp_pkg::INTV_MAX;
						end else if (phase_q != tsrp_pkg::PH_IDLE) begin
							steps_q <= steps_inc;
						end
					end
				end
				tsrp_pkg::ST_EVAL: begin
					case (phase_q)
						tsrp_pkg::PH_ACCEL: begin
							if (steps_q >= ramp_q) begin
								speed_q <= vm_sat;
								phase_q <= tsrp_pkg::PH_CRUISE;
							end
						end
						tsrp_pkg::PH_CRUISE: begin
							if (steps_q >= move_q - ramp_q)
								phase_q <= tsrp_pkg::PH_DECEL;
						end
						tsrp_pkg::PH_DECEL: begin
							if (steps_q >= move_q) begin
								speed_q <= '0;
								phase_q <= tsrp_pkg::PH_IDLE;
								done_q  <= 1'b1;
							end
						end
						default: ;
					endcase
				end
				tsrp_pkg::ST_APPLY: begin
					if (phase_q == tsrp_pkg::PH_ACCEL) begin
						speed_q <= acc_spd;
					end else if (dec_spd[VW-1:FRAC_BITS] == '0) begin
						// below one step per second ends the move
						speed_q <= '0;
						phase_q <= tsrp_pkg::PH_IDLE;
						done_q  <= 1'b1;
					end else begin
						speed_q <= dec_spd;
					end
				end
				tsrp_pkg::ST_INTV: begin
					if (div_done)
						cmp_q <= intv_sat;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == tsrp_pkg::ST_RATE && div_done) begin
			rate_q <= rate_nx;
			inc_q  <= SPEED_SAT;
		end
		if (state_q == tsrp_pkg::ST_INC && div_done)
			inc_q <= inc_sat;
		if (res_load) begin
			res_intv_q  <= cmp_q;
			res_vel_q   <= speed_q;
			res_phase_q <= phase_q;
			res_done_q  <= done_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_vld_q <= 1'b0;
		else if (res_load)
			res_vld_q <= 1'b1;
		else if (res_ready)
			res_vld_q <= 1'b0;
	end

	assign div_go            = go_q;
	assign res_valid         = res_vld_q;
	assign res_step_interval = res_intv_q;
	assign res_velocity      = res_vel_q;
	assign res_phase         = res_phase_q;
	assign res_move_done     = res_done_q;

endmodule

// File: dv/tsrp_profile_checker.sv
`timescale 1ns / 1ps

module tsrp_profile_checker
	import tsrp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	tsrp_cmd_if  cmd,
	tsrp_res_if  res,
	tsrp_cfg_if  cfg,
	output int   mismatches,
	output int   backlog
);

	localparam int FRAC = 16;

	typedef logic [63:0] wide_t;

	localparam wide_t               VEL_SAT   = 64'hFFFF_FFFF;
	localparam logic [VEL_W-1:0]    ONE_Q     = 32'h0001_0000;
	localparam logic [MOVE_W-1:0]   STEP_SAT  = '1;

	typedef struct packed {
		logic [INTV_W-1:0] interval;
		logic [VEL_W-1:0]  speed;
		phase_t            phase;
		logic              done;
	} profile_out_t;

	profile_out_t pending_profiles[$];

	// mirrored registers
	logic [ACC_W-1:0]  accel;
	logic [MAXV_W-1:0] vmax;
	logic [RAMP_W-1:0] ramp_cfg;
	logic [CLK_W-1:0]  tick_hz;

	// mirrored profile state
	logic [MOVE_W-1:0] steps_done;
	logic [MOVE_W-1:0] move_len;
	logic [MOVE_W-1:0] ramp_len;
	logic [VEL_W-1:0]  speed;
	phase_t            motion;
	logic [INTV_W-1:0] interval;

	task automatic flag_mismatch(input string what, input wide_t want, input wide_t got);
		if (mismatches < 100)
			$display("mismatch on %s: expected %0d, got %0d at %0t", what, want, got, $time);
		mismatches++;
	endtask

	// velocity change per step, saturated to the velocity width
	function automatic wide_t speed_step();
		wide_t rate;
		wide_t inc;
		rate = wide_t'(tick_hz) / wide_t'(interval);
		if (rate == 0)
			return VEL_SAT;
		inc = (wide_t'(accel) << FRAC) / rate;
		return (inc > VEL_SAT) ? VEL_SAT : inc;
	endfunction

	function automatic profile_out_t advance_profile(input logic op, input logic [MOVE_W-1:0] len);
		profile_out_t r;
		wide_t s;
		wide_t d;
		wide_t q;
		logic [VEL_W-1:0] v;
		logic finished;
		finished = 1'b0;
		if (op == OP_START) begin
			move_len   = len;
			ramp_len   = ((wide_t'(ramp_cfg) << 1) > wide_t'(len)) ? (len >> 1) : ramp_cfg;
			steps_done = '0;
			speed      = '0;
			motion     = PH_ACCEL;
			interval   = INTV_MAX;
		end else if (motion != PH_IDLE) begin
			if (steps_done != STEP_SAT)
				steps_done = steps_done + 1'b1;
			case (motion)
				PH_ACCEL: begin
					s = wide_t'(speed) + speed_step();
					speed = (s > VEL_SAT) ? '1 : s[VEL_W-1:0];
					if (steps_done >= ramp_len) begin
						speed  = {vmax, {FRAC{1'b0}}};
						motion = PH_CRUISE;
					end
				end
				PH_CRUISE: begin
					if (steps_done >= move_len - ramp_len)
						motion = PH_DECEL;
				end
				default: begin
					d = speed_step();
					speed = (d >= wide_t'(speed)) ? '0 : speed - d[VEL_W-1:0];
					if (speed < ONE_Q || steps_done >= move_len) begin
						speed    = '0;
						motion   = PH_IDLE;
						finished = 1'b1;
					end
				end
			endcase
			// interval holds its value once the velocity is zero
			if (speed != '0) begin
				v = (speed < ONE_Q) ? ONE_Q : speed;
				q = (wide_t'(tick_hz) << FRAC) / (wide_t'(v) << 1);
				interval = (q > 64'd65535) ? INTV_MAX : ((q == 0) ? INTV_W'(1) : q[INTV_W-1:0]);
			end
		end
		r.interval = interval;
		r.speed    = speed;
		r.phase    = motion;
		r.done     = finished;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		profile_out_t want;
		if (!arst_n) begin
			pending_profiles.delete();
			mismatches = 0;
			backlog    = 0;
			accel      = ACCEL_RST;
			vmax       = MAXV_RST;
			ramp_cfg   = RAMP_RST;
			tick_hz    = CLK_RST;
			steps_done = '0;
			move_len   = '0;
			ramp_len   = '0;
			speed      = '0;
			motion     = PH_IDLE;
			interval   = INTV_MAX;
		end else begin
			if (res.valid && res.ready) begin
				if (pending_profiles.size() == 0) begin
					flag_mismatch("result without request", 0, res.step_interval);
				end else begin
					want = pending_profiles.pop_front();
					if (res.step_interval !== want.interval)
						flag_mismatch("step_interval", want.interval, res.step_interval);
					if (res.velocity !== want.speed)
						flag_mismatch("velocity", want.speed, res.velocity);
					if (res.phase !== want.phase)
						flag_mismatch("phase", want.phase, res.phase);
					if (res.move_done !== want.done)
						flag_mismatch("move_done", want.done, res.move_done);
				end
			end
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_ACCEL_RATE:   accel    = cfg.data[ACC_W-1:0];
					CFG_MAX_VELOCITY: vmax     = cfg.data[MAXV_W-1:0];
					CFG_RAMP_STEPS:   ramp_cfg = cfg.data[RAMP_W-1:0];
					CFG_CLOCK_HZ:     tick_hz  = cfg.data[CLK_W-1:0];
					default: ;
				endcase
			end
			if (cmd.valid && cmd.ready)
				pending_profiles.push_back(advance_profile(cmd.op, cmd.move_steps));
			backlog = pending_profiles.size();
		end
	end

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb;
	import tsrp_pkg::*;

	localparam logic OP_TICK = ~OP_START;

	logic clk;
	logic arst_n;

	int mismatches;
	int backlog;
	int sent = 0;
	int send_idle_pct = 30;
	int recv_idle_pct = 58;

	tsrp_cmd_if cmd();
	tsrp_res_if res();
	tsrp_cfg_if cfg();

	trapezoidal_step_rate_profile_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.res    (res),
		.cfg    (cfg)
	);

	tsrp_profile_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.res        (res),
		.cfg        (cfg),
		.mismatches (mismatches),
		.backlog    (backlog)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin : watchdog
		#40_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	task automatic send_request(input logic op, input logic [MOVE_W-1:0] steps);
		int gap;
		if (sent < 430) begin
			send_idle_pct = 30;
			recv_idle_pct = 58;
		end else if (sent < 860) begin
			send_idle_pct = 58;
			recv_idle_pct = 30;
		end else begin
			send_idle_pct = 0;
			recv_idle_pct = 0;
		end
		gap = 0;
		if ($urandom_range(0, 99) < send_idle_pct)
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 160) : $urandom_range(1, 6);
		if (gap > 0) begin
			cmd.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd.valid      <= 1'b1;
		cmd.op         <= op;
		cmd.move_steps <= steps;
		do @(posedge clk); while (!cmd.ready);
		sent++;
	endtask

	// wait until every result is back and the divider has gone quiet
	task automatic settle_block();
		cmd.valid <= 1'b0;
		@(negedge clk);
		while (backlog != 0) @(negedge clk);
		repeat (160) @(posedge clk);
	endtask

	task automatic load_regs(input logic [ACC_W-1:0] a, input logic [MAXV_W-1:0] m,
			input logic [RAMP_W-1:0] r, input logic [CLK_W-1:0] c);
		logic [CFG_DATA_W-1:0] vals [4];
		logic [CFG_IDX_W-1:0]  idx [4];
		vals = '{CFG_DATA_W'(a), CFG_DATA_W'(m), CFG_DATA_W'(r), CFG_DATA_W'(c)};
		idx  = '{CFG_ACCEL_RATE, CFG_MAX_VELOCITY, CFG_RAMP_STEPS, CFG_CLOCK_HZ};
		for (int k = 0; k < 4; k++) begin
			cfg.valid <= 1'b1;
			cfg.index <= idx[k];
			cfg.data  <= vals[k];
			do @(posedge clk); while (!cfg.ready);
		end
		cfg.valid <= 1'b0;
	endtask

	initial begin : result_sink
		int taken;
		int hold;
		taken = 0;
		hold = 0;
		res.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (res.valid && res.ready) begin
				taken++;
				// long hold-off so the block fills up and stalls its input
				if (taken == 150 || taken == 700)
					hold = 400;
			end
			if (hold > 0) begin
				hold--;
				res.ready <= 1'b0;
			end else begin
				res.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	initial begin : stimulus
		int useful;
		int len;
		int ticks;
		int kind;
		int n;
		logic [ACC_W-1:0]  a;
		logic [MAXV_W-1:0] m;
		logic [RAMP_W-1:0] r;
		logic [CLK_W-1:0]  c;
		cmd.valid      = 1'b0;
		cmd.op         = OP_START;
		cmd.move_steps = '0;
		cfg.valid      = 1'b0;
		cfg.index      = CFG_ACCEL_RATE;
		cfg.data       = '0;
		arst_n         = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: tick while idle, zero-length move, longest move,
		// restart while moving, ticks past the move end
		send_request(OP_TICK, MOVE_W'($urandom));
		send_request(OP_START, '0);
		repeat (3) send_request(OP_TICK, MOVE_W'($urandom));
		send_request(OP_START, '1);
		repeat (2) send_request(OP_TICK, MOVE_W'($urandom));
		send_request(OP_START, MOVE_W'(5));
		repeat (6) send_request(OP_TICK, MOVE_W'($urandom));

		// timer clock below the interval: increments saturate, interval floors at one
		settle_block();
		load_regs('1, '1, '1, CLK_W'(1));
		send_request(OP_START, MOVE_W'(6));
		repeat (5) send_request(OP_TICK, MOVE_W'($urandom));

		for (int phase_no = 0; phase_no < 8; phase_no++) begin
			settle_block();
			case (phase_no)
				0: load_regs(ACC_W'(1), MAXV_W'(1), RAMP_W'(0), CLK_W'(100000000));
				1: load_regs(ACCEL_RST, MAXV_RST, RAMP_W'(3), CLK_RST);
				default: begin
					a = ($urandom_range(0, 2) == 0) ? ACC_W'($urandom_range(1, 500))
						: ACC_W'($urandom_range(1, 20'hFFFFF));
					m = MAXV_W'($urandom_range(1, 16'hFFFF));
					r = ($urandom_range(0, 4) == 0) ? RAMP_W'($urandom_range(0, 24'hFFFFFF))
						: RAMP_W'($urandom_range(0, 24));
					c = ($urandom_range(0, 3) == 0) ? CLK_W'($urandom_range(1, 70000))
						: CLK_W'($urandom_range(1, 100000000));
					load_regs(a, m, r, c);
				end
			endcase
			useful = 0;
			while (useful < 163) begin
				kind = $urandom_range(0, 9);
				len = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 24'hFFFFFF)
					: $urandom_range(0, 40);
				if (kind < 9) begin
					if (kind < 7)
						ticks = (len > 64) ? $urandom_range(1, 30) : len + $urandom_range(0, 2);
					else
						ticks = (len > 64) ? $urandom_range(0, 30) : $urandom_range(0, len / 2);
					send_request(OP_START, MOVE_W'(len));
					repeat (ticks) send_request(OP_TICK, MOVE_W'($urandom));
					useful += 1 + ((ticks < len) ? ticks : len);
				end else begin
					// noise: random operations with random lengths
					n = $urandom_range(1, 4);
					repeat (n) send_request(logic'($urandom_range(0, 1)),
						MOVE_W'($urandom_range(0, 24'hFFFFFF)));
					useful += n;
				end
			end
		end

		settle_block();
		if (mismatches == 0 && backlog == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
